// ===== rtl/core/sorted_key_group_insert_unit_assert.svh =====
// assertion macros for the sorted key group insert unit
`ifndef SORTED_KEY_GROUP_INSERT_UNIT_ASSERT_SVH
`define SORTED_KEY_GROUP_INSERT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge out of reset
`define SKGI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skgi check failed");

// next-cycle implication
`define SKGI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skgi check failed");

`else

`define SKGI_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SKGI_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/skgi_pkg.sv =====
`default_nettype none

package skgi_pkg;

  // fixed field widths
  localparam int KEY_W  = 32;
  localparam int USER_W = 12;

  // default sizes
  localparam int TABLE_DEPTH_DEF     = 1024;
  localparam int MAX_USER_NUMBER_DEF = 4095;

  // cells per group in the first level of the match reduction
  localparam int GROUP_SIZE = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED1,
    ST_RED2,
    ST_UPD
  } state_t;

  // control handed to every cell of the chain
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic found;
    logic full;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/skgi_cell.sv =====
`default_nettype none

module skgi_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 11
) (
  input  wire logic                              clk,
  input  wire skgi_pkg::cell_ctrl_t              ctrl,
  input  wire logic signed [skgi_pkg::KEY_W-1:0] new_key,
  input  wire logic [skgi_pkg::USER_W-1:0]       new_user,
  input  wire logic [CNT_W-1:0]                  count,
  input  wire logic signed [skgi_pkg::KEY_W-1:0] left_key,
  input  wire logic [skgi_pkg::USER_W-1:0]       left_head,
  input  wire logic                              left_lt,
  output logic signed [skgi_pkg::KEY_W-1:0]      key,
  output logic [skgi_pkg::USER_W-1:0]            head,
  output logic                                   lt,
  output logic                                   eq,
  output logic                                   sel
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic occ;
  logic at_end;

  // occupancy follows from the entry count
  assign occ    = (MY_IDX < count);
  assign at_end = (MY_IDX == count);

  // first cell whose key is not below the new key, or the free cell past the end
  assign sel = (occ ? !lt : at_end) && left_lt;

  // compare flags, loaded once per word
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt <= occ && (key < new_key);
      eq <= occ && (key == new_key);
    end
  end

  // head update on a hit, insert or shift up on a new key
  always_ff @(posedge clk) begin
    if (ctrl.upd_en) begin
      if (ctrl.found) begin
        if (eq) begin
          head <= new_user;
        end
      end else if (!ctrl.full) begin
        if (sel) begin
          key  <= new_key;
          head <= new_user;
        end else if ((occ || at_end) && !left_lt) begin
          key  <= left_key;
          head <= left_head;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/skgi_reduce.sv =====
`default_nettype none

module skgi_reduce #(
  parameter int DEPTH  = skgi_pkg::TABLE_DEPTH_DEF,
  parameter int SLOT_W = 10
) (
  input  wire logic                        clk,
  input  wire logic                        sel   [DEPTH],
  input  wire logic                        eq    [DEPTH],
  input  wire logic [skgi_pkg::USER_W-1:0] heads [DEPTH],
  output logic                             found,
  output logic [SLOT_W-1:0]                slot,
  output logic [skgi_pkg::USER_W-1:0]      head
);

  localparam int GS         = skgi_pkg::GROUP_SIZE;
  localparam int NUM_GROUPS = (DEPTH + GS - 1) / GS;

  logic                        g_found_next [NUM_GROUPS];
  logic [SLOT_W-1:0]           g_slot_next  [NUM_GROUPS];
  logic [skgi_pkg::USER_W-1:0] g_head_next  [NUM_GROUPS];
  logic                        g_found      [NUM_GROUPS];
  logic [SLOT_W-1:0]           g_slot       [NUM_GROUPS];
  logic [skgi_pkg::USER_W-1:0] g_head       [NUM_GROUPS];
  logic                        found_next;
  logic [SLOT_W-1:0]           slot_next;
  logic [skgi_pkg::USER_W-1:0] head_next;

  // first level: and-or over each group of cells, selection is one-hot
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      g_found_next[g] = 1'b0;
      g_slot_next[g]  = '0;
      g_head_next[g]  = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < DEPTH) begin
          if (sel[g * GS + k]) begin
            g_found_next[g] = g_found_next[g] | eq[g * GS + k];
            g_slot_next[g]  = g_slot_next[g] | SLOT_W'(g * GS + k);
            g_head_next[g]  = g_head_next[g] | heads[g * GS + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    g_found <= g_found_next;
    g_slot  <= g_slot_next;
    g_head  <= g_head_next;
  end

  // second level: or across the groups
  always_comb begin
    found_next = 1'b0;
    slot_next  = '0;
    head_next  = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      found_next = found_next | g_found[g];
      slot_next  = slot_next | g_slot[g];
      head_next  = head_next | g_head[g];
    end
  end

  always_ff @(posedge clk) begin
    found <= found_next;
    slot  <= slot_next;
    head  <= head_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_key_group_insert_unit.sv =====
// channel   direction  handshake            word fields
// ------    ---------  -------------------  ---------------------------------------------
// input     in         start, busy          group_key, user_number
// result    out        done (one cycle)     key_was_new, slot_index, previous_head,
//                                           table_full
//
// after accept, every cell compares, two registered levels of match reduction follow, then
// the chain shifts or updates a head and done is registered from that update step.
// busy is high after accept through the update step; a new word can be taken in the done cycle.
// rst is synchronous: it clears the sequencer, the entry count and the strobe.
// table and link contents are not cleared; only entries below the count are read.
// the receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none

module sorted_key_group_insert_unit #(
  parameter int TABLE_DEPTH     = skgi_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_USER_NUMBER = skgi_pkg::MAX_USER_NUMBER_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [skgi_pkg::KEY_W-1:0] group_key,
  input  wire logic [skgi_pkg::USER_W-1:0]       user_number,
  output logic                                   done,
  output logic                                   key_was_new,
  output logic [$clog2(TABLE_DEPTH)-1:0]         slot_index,
  output logic [skgi_pkg::USER_W-1:0]            previous_head,
  output logic                                   table_full
);

`include "sorted_key_group_insert_unit_assert.svh"

  localparam int SLOT_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int LINK_AW = $clog2(MAX_USER_NUMBER + 1);
  localparam int UW      = skgi_pkg::USER_W;
  localparam int WIDE_W  = UW + LINK_AW;

  skgi_pkg::state_t     state;
  skgi_pkg::state_t     state_next;
  skgi_pkg::cell_ctrl_t ctrl;

  logic signed [skgi_pkg::KEY_W-1:0] key_reg;
  logic [UW-1:0]                     user_reg;
  logic [CNT_W-1:0]                  entry_count;

  logic signed [skgi_pkg::KEY_W-1:0] cell_key  [TABLE_DEPTH];
  logic [UW-1:0]                     cell_head [TABLE_DEPTH];
  logic                              cell_lt   [TABLE_DEPTH];
  logic                              cell_eq   [TABLE_DEPTH];
  logic                              cell_sel  [TABLE_DEPTH];

  logic              found;
  logic [SLOT_W-1:0] found_slot;
  logic [UW-1:0]     found_head;
  logic              full;
  logic              upd;

  logic [UW-1:0]     link_mem [MAX_USER_NUMBER + 1];
  logic [WIDE_W-1:0] user_wide;
  logic [LINK_AW-1:0] link_addr;
  logic              link_ok;

  // sequencer register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skgi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and cell control
  always_comb begin
    state_next  = state;
    ctrl.cmp_en = 1'b0;
    ctrl.upd_en = 1'b0;
    ctrl.found  = found;
    ctrl.full   = full;
    unique case (state)
      skgi_pkg::ST_IDLE: begin
        if (start) begin
          state_next = skgi_pkg::ST_CMP;
        end
      end
      skgi_pkg::ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_next  = skgi_pkg::ST_RED1;
      end
      skgi_pkg::ST_RED1: begin
        state_next = skgi_pkg::ST_RED2;
      end
      skgi_pkg::ST_RED2: begin
        state_next = skgi_pkg::ST_UPD;
      end
      skgi_pkg::ST_UPD: begin
        ctrl.upd_en = 1'b1;
        state_next  = skgi_pkg::ST_IDLE;
      end
      default: begin
        state_next = skgi_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state != skgi_pkg::ST_IDLE);
  assign upd        = ctrl.upd_en;
  assign full       = (entry_count == CNT_W'(TABLE_DEPTH)) && !found;

  // input word capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      key_reg  <= group_key;
      user_reg <= user_number;
    end
  end

  // chain of cells, each fed by its lower neighbor, the first by the input word
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic signed [skgi_pkg::KEY_W-1:0] left_key;
    logic [UW-1:0]                     left_head;
    logic                              left_lt;

    if (i == 0) begin : g_first
      assign left_key  = key_reg;
      assign left_head = user_reg;
      assign left_lt   = 1'b1;
    end else begin : g_rest
      assign left_key  = cell_key[i-1];
      assign left_head = cell_head[i-1];
      assign left_lt   = cell_lt[i-1];
    end

    skgi_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_key   (key_reg),
      .new_user  (user_reg),
      .count     (entry_count),
      .left_key  (left_key),
      .left_head (left_head),
      .left_lt   (left_lt),
      .key       (cell_key[i]),
      .head      (cell_head[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i]),
      .sel       (cell_sel[i])
    );
  end

  // match position, hit flag and former head
  skgi_reduce #(
    .DEPTH  (TABLE_DEPTH),
    .SLOT_W (SLOT_W)
  ) u_reduce (
    .clk   (clk),
    .sel   (cell_sel),
    .eq    (cell_eq),
    .heads (cell_head),
    .found (found),
    .slot  (found_slot),
    .head  (found_head)
  );

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (upd && !found && !full) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // next-link store, skipped for users above the limit
  assign user_wide = {{LINK_AW{1'b0}}, user_reg};
  assign link_addr = user_wide[LINK_AW-1:0];
  assign link_ok   = (user_wide <= WIDE_W'(MAX_USER_NUMBER));

  always_ff @(posedge clk) begin
    if (upd && !full && link_ok) begin
      link_mem[link_addr] <= found ? found_head : '0;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= upd;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (upd) begin
      key_was_new   <= !found && !full;
      table_full    <= full;
      slot_index    <= full ? '0 : found_slot;
      previous_head <= found ? found_head : '0;
    end
  end

  `SKGI_ASSERT_NOW(a_new_not_full, clk, rst, done, !(key_was_new && table_full))
  `SKGI_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, entry_count <= CNT_W'(TABLE_DEPTH))
  `SKGI_ASSERT_NEXT(a_done_after_upd, clk, rst, state == skgi_pkg::ST_UPD, done)
  `SKGI_ASSERT_NOW(a_new_grows, clk, rst, done && key_was_new, entry_count == $past(entry_count) + CNT_W'(1))
  `SKGI_ASSERT_NOW(a_full_count, clk, rst, done && table_full, entry_count == CNT_W'(TABLE_DEPTH))

endmodule

`default_nettype wire
